@@ sv/linked_block_allocator_core_assert.svh @@
// Assertion macros for the linked block allocator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LINKED_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define LINKED_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define LBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define LBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBA_ASSERT_NOW(lbl, ante, cons, msg)
`define LBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/lba_pkg.sv @@
package lba_pkg;

  localparam int IDX_W       = 6;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;
  localparam logic [7:0] TAG_BASE = 8'd65;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_USED  = 2'd2,
    ST_FULL  = 2'd3
  } lba_status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHECK = 2'd1,
    S_SCAN  = 2'd2
  } lba_state_t;

  typedef struct packed {
    logic             set_en;
    logic [IDX_W-1:0] set_idx;
  } lba_map_cmd_t;

endpackage

@@ sv/lba_tag_mem.sv @@
module lba_tag_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lba_used_map.sv @@
module lba_used_map #(
  parameter int NUM_BLOCKS = 16,
  parameter int AW         = 4,
  parameter int FW         = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lba_pkg::lba_map_cmd_t cmd,
  input  logic [AW-1:0]        rd_idx,
  output logic                 rd_used,
  output logic [FW-1:0]        free_cnt
);
  import lba_pkg::*;

  logic [NUM_BLOCKS-1:0] used_r;
  logic [FW-1:0]         free_r;

  // Mark a block used and drop the free count by one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      free_r <= FW'(NUM_BLOCKS);
    end else if (cmd.set_en) begin
      used_r[cmd.set_idx[AW-1:0]] <= 1'b1;
      free_r                      <= free_r - 1'b1;
    end
  end

  assign rd_used  = used_r[rd_idx];
  assign free_cnt = free_r;

endmodule

@@ sv/linked_block_allocator_core.sv @@
// A rejection or empty-file beat is chosen in S_CHECK, a claimed block beat in S_SCAN;
// each goes through the output register. A new request is taken only back in S_IDLE.
// The circular scan visits one block per cycle through the used map and the tag memory
// port while the output register can load; a free block holds the scan until it can.
// Reset (rst_n low, synchronous): every block free, file count zero,
// output channel empty. The tag memory is not cleared.
module linked_block_allocator_core #(
  parameter int NUM_BLOCKS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_start_block,
  input  logic [7:0] in_block_count,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_block_valid,
  output logic [5:0] out_block_index,
  output logic [7:0] out_owner,
  output logic [6:0] out_free_left,
  output logic       out_last
);
  import lba_pkg::*;

`include "linked_block_allocator_core_assert.svh"

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int FW = $clog2(NUM_BLOCKS + 1);

  lba_state_t state_r, state_nxt;

  // Request context, held for the whole request.
  logic [7:0]       start_r;
  logic [7:0]       len_r;
  logic [AW-1:0]    pos_r;
  logic [CNT_W-1:0] claimed_r;
  logic [7:0]       tag_r;
  logic [FW-1:0]    snap_r;
  logic [7:0]       files_r;

  // Output register: one result beat waits here while the next is prepared.
  logic             out_valid_r;
  lba_status_t      o_status_r;
  logic             o_bvalid_r;
  logic [5:0]       o_index_r;
  logic [7:0]       o_owner_r;
  logic [6:0]       o_free_r;
  logic             o_last_r;

  logic             in_accept;
  logic             load;
  logic             emit;
  lba_status_t      e_status;
  logic             e_bvalid;
  logic [7:0]       e_owner;
  logic [6:0]       e_free;
  logic             e_last;
  logic             check_done;
  logic             grant;
  logic             claim;
  logic             advance;
  logic             in_range;
  logic             too_long;
  logic [AW-1:0]    pos_next;

  logic             rd_used;
  logic [FW-1:0]    free_cnt;
  lba_map_cmd_t     map_cmd;
  logic             tag_re;
  logic [7:0]       tag_rdata;

  assign in_accept = in_valid && in_ready;
  assign load      = !out_valid_r || out_ready;
  assign in_range  = start_r < 8'(NUM_BLOCKS);
  assign too_long  = (len_r > 8'(free_cnt)) || (len_r > 8'(MAX_RESULTS));
  assign pos_next  = (pos_r == AW'(NUM_BLOCKS - 1)) ? '0 : pos_r + 1'b1;

  // Read the start block's owner tag as the request arrives; it is needed
  // only on a used-start rejection.
  assign tag_re = in_accept && (in_start_block < 8'(NUM_BLOCKS));

  assign map_cmd.set_en  = claim;
  assign map_cmd.set_idx = IDX_W'(pos_r);

  lba_used_map #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .AW        (AW),
    .FW        (FW)
  ) u_used_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (map_cmd),
    .rd_idx  (pos_r),
    .rd_used (rd_used),
    .free_cnt(free_cnt)
  );

  lba_tag_mem #(
    .DEPTH(NUM_BLOCKS),
    .AW   (AW)
  ) u_tag_mem (
    .clk  (clk),
    .we   (claim),
    .waddr(pos_r),
    .wdata(tag_r),
    .re   (tag_re),
    .raddr(in_start_block[AW-1:0]),
    .rdata(tag_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (check_done) state_nxt = (emit) ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (claim && e_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the control: which beat to emit and what to update.
  always_comb begin
    in_ready   = 1'b0;
    emit       = 1'b0;
    e_status   = ST_OK;
    e_bvalid   = 1'b0;
    e_owner    = '0;
    e_free     = 7'(free_cnt);
    e_last     = 1'b1;
    check_done = 1'b0;
    grant      = 1'b0;
    claim      = 1'b0;
    advance    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_CHECK: begin
        priority if (!in_range) begin
          emit     = 1'b1;
          e_status = ST_RANGE;
        end else if (rd_used) begin
          emit     = 1'b1;
          e_status = ST_USED;
          e_owner  = tag_rdata;
        end else if (too_long) begin
          emit     = 1'b1;
          e_status = ST_FULL;
        end else if (len_r == '0) begin
          // Zero length: grant a file number, claim nothing.
          emit    = 1'b1;
          e_owner = TAG_BASE + files_r;
        end else begin
          emit = 1'b0;
        end
        check_done = emit ? load : 1'b1;
        grant      = check_done && in_range && !rd_used && !too_long;
      end
      S_SCAN: begin
        // Skip used blocks; claim a free one when the output register can load.
        emit     = !rd_used;
        e_bvalid = 1'b1;
        e_owner  = tag_r;
        e_free   = 7'(snap_r);
        e_last   = (8'(claimed_r) + 8'd1) == len_r;
        claim    = emit && load;
        advance  = rd_used || load;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      files_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= emit;
      end
      if (grant) begin
        files_r <= files_r + 1'b1;
      end
    end
  end

  // Request context and output payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      start_r   <= in_start_block;
      len_r     <= in_block_count;
      pos_r     <= in_start_block[AW-1:0];
      claimed_r <= '0;
    end
    if (state_r == S_CHECK) begin
      snap_r <= free_cnt;
      tag_r  <= TAG_BASE + files_r;
    end
    if (advance) begin
      pos_r <= pos_next;
    end
    if (claim) begin
      claimed_r <= claimed_r + 1'b1;
    end
    if (load && emit) begin
      o_status_r <= e_status;
      o_bvalid_r <= e_bvalid;
      o_index_r  <= e_bvalid ? 6'(pos_r) : 6'd0;
      o_owner_r  <= e_owner;
      o_free_r   <= e_free;
      o_last_r   <= e_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_block_valid = o_bvalid_r;
  assign out_block_index = o_index_r;
  assign out_owner       = o_owner_r;
  assign out_free_left   = o_free_r;
  assign out_last        = o_last_r;

  // A claimed block beat always carries an ok status.
  `LBA_ASSERT_NOW(a_claim_ok, out_valid_r && o_bvalid_r, o_status_r == ST_OK,
                  "claimed block beat without ok status")
  // The scan never runs past the requested length.
  `LBA_ASSERT_NOW(a_scan_len, state_r == S_SCAN, 8'(claimed_r) < len_r,
                  "scan claimed more blocks than requested")
  // The free count stays within the block count.
  `LBA_ASSERT_NOW(a_free_bound, 1'b1, free_cnt <= FW'(NUM_BLOCKS),
                  "free count above block count")
  // A taken request is checked in the next cycle.
  `LBA_ASSERT_NEXT(a_accept_check, in_accept, state_r == S_CHECK,
                   "accepted request did not enter check")

endmodule
